@@ hw/rtl/tfpu_pkg.sv @@
// Shared types and constants for the three-fringe phase unwrap block.
`default_nettype none

package tfpu_pkg;

    // Fixed widths of the coefficient registers and of the phase output.
    localparam int COEF_BITS     = 16;
    localparam int PHASE_BITS    = 40;
    localparam int APB_DATA_BITS = 32;
    localparam int ADDR_BITS     = 5;

    // Angle accumulator of the CORDIC: 2^32 units per turn, with headroom.
    localparam int ACC_BITS   = 35;
    localparam int TABLE_LEN  = 24;
    localparam int STEP_BITS  = 5;

    // Number of terms in each dot product.
    localparam int MAC_TERMS  = 3;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_COS_X = 3'd0,
        REG_COS_Y = 3'd1,
        REG_COS_Z = 3'd2,
        REG_SIN_X = 3'd3,
        REG_SIN_Y = 3'd4,
        REG_SIN_Z = 3'd5
    } reg_idx_t;

    // Sample selector of the shared multiply step.
    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_Y = 2'd1,
        SEL_Z = 2'd2
    } sample_sel_t;

    typedef logic signed [ACC_BITS-1:0] angle_acc_t;

    // atan(2^-i) in units of 2^32 per turn.
    localparam angle_acc_t ATAN_TAB [TABLE_LEN] = '{
        35'sd536870912, 35'sd316933406, 35'sd167458907, 35'sd85004756,
        35'sd42667331,  35'sd21354465,  35'sd10679838,  35'sd5340245,
        35'sd2670163,   35'sd1335087,   35'sd667544,    35'sd333772,
        35'sd166886,    35'sd83443,     35'sd41722,     35'sd20861,
        35'sd10430,     35'sd5215,      35'sd2608,      35'sd1304,
        35'sd652,       35'sd326,       35'sd163,       35'sd81
    };

    // The six ellipse coefficients, signed Q2.14.
    typedef struct packed {
        logic signed [COEF_BITS-1:0] cos_x;
        logic signed [COEF_BITS-1:0] cos_y;
        logic signed [COEF_BITS-1:0] cos_z;
        logic signed [COEF_BITS-1:0] sin_x;
        logic signed [COEF_BITS-1:0] sin_y;
        logic signed [COEF_BITS-1:0] sin_z;
    } coef_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 load_in;
        logic                 mul_en;
        sample_sel_t          mul_sel;
        logic                 acc_en;
        logic                 acc_first;
        logic                 cordic_init;
        logic                 cordic_step;
        logic [STEP_BITS-1:0] step_idx;
        logic                 round_en;
        logic                 diff_en;
        logic                 commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/tfpu_regs.sv @@
// APB configuration registers holding the six ellipse coefficients.
`default_nettype none

module tfpu_regs import tfpu_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_BITS-1:0]     paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    output coef_t                         coefs
);

    coef_t          coef_reg;
    coef_t          coef_next;
    logic           wr_en;
    logic [2:0]     reg_idx;
    logic signed [COEF_BITS-1:0] wr_val;
    logic signed [COEF_BITS-1:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_val  = pwdata[COEF_BITS-1:0];

    // Write decode: addresses past the register list are ignored.
    always_comb
    begin
        coef_next = coef_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(reg_idx))
                REG_COS_X: coef_next.cos_x = wr_val;
                REG_COS_Y: coef_next.cos_y = wr_val;
                REG_COS_Z: coef_next.cos_z = wr_val;
                REG_SIN_X: coef_next.sin_x = wr_val;
                REG_SIN_Y: coef_next.sin_y = wr_val;
                REG_SIN_Z: coef_next.sin_z = wr_val;
                default:   coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.cos_x <= -16'sd4162;
            coef_reg.cos_y <= 16'sd8189;
            coef_reg.cos_z <= -16'sd9069;
            coef_reg.sin_x <= 16'sd7800;
            coef_reg.sin_y <= -16'sd316;
            coef_reg.sin_z <= -16'sd15757;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // Read decode: the coefficient comes back sign extended.
    always_comb
    begin
        unique case (reg_idx_t'(reg_idx))
            REG_COS_X: rd_val = coef_reg.cos_x;
            REG_COS_Y: rd_val = coef_reg.cos_y;
            REG_COS_Z: rd_val = coef_reg.cos_z;
            REG_SIN_X: rd_val = coef_reg.sin_x;
            REG_SIN_Y: rd_val = coef_reg.sin_y;
            REG_SIN_Z: rd_val = coef_reg.sin_z;
            default:   rd_val = '0;
        endcase
    end

    assign prdata = APB_DATA_BITS'(rd_val);
    assign coefs  = coef_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tfpu_ctrl.sv @@
// Controller state machine that sequences the dot products, CORDIC and unwrap.
`default_nettype none

module tfpu_ctrl import tfpu_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dp_cmd_t   cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MAC    = 7'b0000010,
        ST_PREROT = 7'b0000100,
        ST_ITER   = 7'b0001000,
        ST_ROUND  = 7'b0010000,
        ST_DIFF   = 7'b0100000,
        ST_COMMIT = 7'b1000000
    } state_t;

    localparam logic [STEP_BITS-1:0] ITER_LAST = STEP_BITS'(CORDIC_STEPS - 1);
    localparam logic [STEP_BITS-1:0] MAC_LAST  = STEP_BITS'(MAC_TERMS);

    state_t               state_reg;
    state_t               state_next;
    logic [STEP_BITS-1:0] cnt_reg;
    logic [STEP_BITS-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel  = SEL_X;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = ST_MAC;
                end
            end
            ST_MAC:
            begin
                // Multiply term k while the product of term k-1 accumulates.
                cmd.mul_en    = (cnt_reg != MAC_LAST);
                cmd.mul_sel   = sample_sel_t'(cnt_reg[1:0]);
                cmd.acc_en    = (cnt_reg != '0);
                cmd.acc_first = (cnt_reg == STEP_BITS'(1));
                if (cnt_reg == MAC_LAST)
                begin
                    state_next = ST_PREROT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PREROT:
            begin
                cmd.cordic_init = 1'b1;
                cnt_next        = '0;
                state_next      = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.cordic_step = 1'b1;
                cmd.step_idx    = cnt_reg;
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = ST_ROUND;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // Wait until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag of the result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tfpu_datapath.sv @@
// Datapath: dot products, vectoring CORDIC, rounding and phase unwrap.
`default_nettype none

module tfpu_datapath import tfpu_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ANGLE_BITS  = 16,
    parameter int TURN_BITS   = 24
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dp_cmd_t                       cmd,
    input  wire coef_t                         coefs,
    input  wire logic signed [SAMPLE_BITS-1:0] x_in,
    input  wire logic signed [SAMPLE_BITS-1:0] y_in,
    input  wire logic signed [SAMPLE_BITS-1:0] z_in,
    output logic        [PHASE_BITS-1:0]       phase_out,
    output logic        [ANGLE_BITS:0]         angle_out,
    output logic        [TURN_BITS-1:0]        turns_out,
    output logic                               sat_out
);

    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int SUM_W  = PROD_W + 2;
    localparam int DW     = PROD_W + 4;
    localparam int SH     = 32 - ANGLE_BITS;
    localparam int AW     = ANGLE_BITS + 1;
    localparam int FW     = (TURN_BITS + ANGLE_BITS + 3 > PHASE_BITS + 2) ?
                            (TURN_BITS + ANGLE_BITS + 3) : (PHASE_BITS + 2);

    localparam angle_acc_t HALF32 = angle_acc_t'(64'sd1 <<< 31);
    localparam logic signed [ACC_BITS:0] RND    = (ACC_BITS+1)'(64'sd1 <<< (SH - 1));
    localparam logic signed [ACC_BITS:0] HALF_R = (ACC_BITS+1)'(64'sd1 <<< (ANGLE_BITS - 1));
    localparam logic signed [FW-1:0] HALF_F = FW'(64'sd1 <<< (ANGLE_BITS - 1));
    localparam logic signed [FW-1:0] TURN_F = FW'(64'sd1 <<< ANGLE_BITS);
    localparam logic signed [TURN_BITS-1:0] TMAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TMIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    // Captured samples.
    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg, z_reg;

    // Multiply and accumulate.
    logic signed [COEF_BITS-1:0]   cc_sel, sc_sel;
    logic signed [SAMPLE_BITS-1:0] smp_sel;
    logic signed [PROD_W-1:0]      prod_c_reg, prod_s_reg;
    logic signed [SUM_W-1:0]       cacc_reg, sacc_reg;

    // CORDIC.
    logic signed [DW-1:0] c_reg, c_next;
    logic signed [DW-1:0] s_reg, s_next;
    logic signed [DW-1:0] c_sh, s_sh, c_ext, s_ext;
    angle_acc_t           ang_acc_reg, ang_acc_next;
    logic                 zero_reg;

    // Rounding.
    logic signed [ACC_BITS:0] rsum, rsh;
    logic signed [AW-1:0]     ang_reg, ang_next;

    // Unwrap.
    logic signed [FW-1:0]          pfull_reg, pfull;
    logic signed [FW-1:0]          diff_reg;
    logic signed [FW-1:0]          pcorr;
    logic signed [PHASE_BITS-1:0]  prev_reg;
    logic signed [TURN_BITS-1:0]   turns_reg, turns_next;
    logic                          sat_next;
    logic                          jump;

    // Result register.
    logic [PHASE_BITS-1:0] res_phase_reg;
    logic [ANGLE_BITS:0]   res_angle_reg;
    logic [TURN_BITS-1:0]  res_turns_reg;
    logic                  res_sat_reg;

    // Operand selection for the two shared multipliers.
    always_comb
    begin
        case (cmd.mul_sel)
            SEL_X:
            begin
                cc_sel  = coefs.cos_x;
                sc_sel  = coefs.sin_x;
                smp_sel = x_reg;
            end
            SEL_Y:
            begin
                cc_sel  = coefs.cos_y;
                sc_sel  = coefs.sin_y;
                smp_sel = y_reg;
            end
            SEL_Z:
            begin
                cc_sel  = coefs.cos_z;
                sc_sel  = coefs.sin_z;
                smp_sel = z_reg;
            end
            default:
            begin
                cc_sel  = '0;
                sc_sel  = '0;
                smp_sel = '0;
            end
        endcase
    end

    // Input capture, products and dot-product sums.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
        if (cmd.mul_en)
        begin
            prod_c_reg <= cc_sel * smp_sel;
            prod_s_reg <= sc_sel * smp_sel;
        end
        if (cmd.acc_en)
        begin
            if (cmd.acc_first)
            begin
                cacc_reg <= SUM_W'(prod_c_reg);
                sacc_reg <= SUM_W'(prod_s_reg);
            end
            else
            begin
                cacc_reg <= cacc_reg + SUM_W'(prod_c_reg);
                sacc_reg <= sacc_reg + SUM_W'(prod_s_reg);
            end
        end
    end

    // CORDIC: half-turn prerotation for a negative cosine term, then one
    // micro-rotation per cycle.
    assign c_ext = DW'(cacc_reg);
    assign s_ext = DW'(sacc_reg);
    assign c_sh  = c_reg >>> cmd.step_idx;
    assign s_sh  = s_reg >>> cmd.step_idx;

    always_comb
    begin
        c_next       = c_reg;
        s_next       = s_reg;
        ang_acc_next = ang_acc_reg;
        if (cmd.cordic_init)
        begin
            if (cacc_reg < 0)
            begin
                c_next       = -c_ext;
                s_next       = -s_ext;
                ang_acc_next = (sacc_reg >= 0) ? HALF32 : -HALF32;
            end
            else
            begin
                c_next       = c_ext;
                s_next       = s_ext;
                ang_acc_next = '0;
            end
        end
        else if (cmd.cordic_step)
        begin
            if (s_reg > 0)
            begin
                c_next       = c_reg + s_sh;
                s_next       = s_reg - c_sh;
                ang_acc_next = ang_acc_reg + ATAN_TAB[cmd.step_idx];
            end
            else
            begin
                c_next       = c_reg - s_sh;
                s_next       = s_reg + c_sh;
                ang_acc_next = ang_acc_reg - ATAN_TAB[cmd.step_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg       <= c_next;
        s_reg       <= s_next;
        ang_acc_reg <= ang_acc_next;
        if (cmd.cordic_init)
        begin
            zero_reg <= (cacc_reg == '0) && (sacc_reg == '0);
        end
    end

    // Round half up to the output angle unit, clamp to half a turn, and give zero for a zero vector.
    assign rsum = $signed({ang_acc_reg[ACC_BITS-1], ang_acc_reg}) + RND;
    assign rsh  = rsum >>> SH;

    always_comb
    begin
        if (zero_reg)
        begin
            ang_next = '0;
        end
        else if (rsh > HALF_R)
        begin
            ang_next = HALF_R[AW-1:0];
        end
        else if (rsh < -HALF_R)
        begin
            ang_next = -HALF_R[AW-1:0];
        end
        else
        begin
            ang_next = rsh[AW-1:0];
        end
    end

    // Phase before unwrap and its jump from the previous phase.
    assign pfull = FW'(ang_reg) + (FW'(turns_reg) <<< ANGLE_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.round_en)
        begin
            ang_reg <= ang_next;
        end
        if (cmd.diff_en)
        begin
            pfull_reg <= pfull;
            diff_reg  <= pfull - FW'(prev_reg);
        end
    end

    // Unwrap: a jump beyond half a turn steps the turn count unless it is
    // already at its limit.
    assign jump = (diff_reg > HALF_F) || (diff_reg < -HALF_F);

    always_comb
    begin
        turns_next = turns_reg;
        pcorr      = pfull_reg;
        sat_next   = 1'b0;
        if (jump)
        begin
            if (diff_reg < 0)
            begin
                if (turns_reg != TMAX)
                begin
                    turns_next = turns_reg + 1'b1;
                    pcorr      = pfull_reg + TURN_F;
                end
                else
                begin
                    sat_next = 1'b1;
                end
            end
            else
            begin
                if (turns_reg != TMIN)
                begin
                    turns_next = turns_reg - 1'b1;
                    pcorr      = pfull_reg - TURN_F;
                end
                else
                begin
                    sat_next = 1'b1;
                end
            end
        end
    end

    // Unwrap state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            turns_reg <= '0;
        end
        else if (cmd.commit)
        begin
            prev_reg  <= pcorr[PHASE_BITS-1:0];
            turns_reg <= turns_next;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_phase_reg <= pcorr[PHASE_BITS-1:0];
            res_angle_reg <= ang_reg;
            res_turns_reg <= turns_next;
            res_sat_reg   <= sat_next;
        end
    end

    assign phase_out = res_phase_reg;
    assign angle_out = res_angle_reg;
    assign turns_out = res_turns_reg;
    assign sat_out   = res_sat_reg;

endmodule

`default_nettype wire

@@ hw/rtl/three_fringe_phase_unwrap.sv @@
// An accepted input steps through the dot-product, CORDIC, rounding, unwrap
// and commit states; a new input is taken only once the last is committed.
// The 16-step CORDIC loop runs on one shared shift-add unit.
// The result register lets the next item be accepted while a result waits.
// Reset (rst_n, asynchronous, active low) clears the phase and turn count
// and loads the default coefficients.
`default_nettype none

module three_fringe_phase_unwrap import tfpu_pkg::*;
#(
    parameter int SAMPLE_BITS  = 16,
    parameter int ANGLE_BITS   = 16,
    parameter int TURN_BITS    = 24,
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Input stream.
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // x_sample, y_sample, z_sample, zero padding
    input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Result stream.
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // unwrapped_phase, wrapped_angle, turn_count, zero padding
    output logic [((PHASE_BITS+ANGLE_BITS+1+TURN_BITS+7)/8)*8-1:0] m_axis_tdata,
    // turn_saturated
    output logic                          m_axis_tuser,
    // Configuration port.
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_BITS-1:0]     paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    localparam int OUT_TW = ((PHASE_BITS + ANGLE_BITS + 1 + TURN_BITS + 7) / 8) * 8;

    coef_t                    coefs;
    dp_cmd_t                  cmd;
    logic [PHASE_BITS-1:0]    phase_out;
    logic [ANGLE_BITS:0]      angle_out;
    logic [TURN_BITS-1:0]     turns_out;
    logic                     sat_out;

    tfpu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    tfpu_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    tfpu_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ANGLE_BITS  (ANGLE_BITS),
        .TURN_BITS   (TURN_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .coefs     (coefs),
        .x_in      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .y_in      (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .z_in      (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .phase_out (phase_out),
        .angle_out (angle_out),
        .turns_out (turns_out),
        .sat_out   (sat_out)
    );

    // Pack the result fields from the lowest bit up.
    assign m_axis_tdata = OUT_TW'({turns_out, angle_out, phase_out});
    assign m_axis_tuser = sat_out;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for three_fringe_phase_unwrap with a local phase demodulation model.
module tb;
    import tfpu_pkg::*;

    localparam int SAMPLE_W     = 16;
    localparam int ANGLE_W      = 16;
    localparam int TURN_W       = 24;
    localparam int CORDIC_ITERS = 16;
    localparam int NUM_COEFS    = 6;
    localparam int IN_W         = ((3*SAMPLE_W+7)/8)*8;
    localparam int OUT_W        = ((PHASE_BITS+ANGLE_W+1+TURN_W+7)/8)*8;
    localparam int ACC_SHIFT    = 32 - ANGLE_W;

    localparam longint ONE_TURN  = longint'(1) << ANGLE_W;
    localparam longint HALF_TURN = longint'(1) << (ANGLE_W-1);
    localparam longint HALF_ACC  = longint'(1) << 31;
    localparam longint TURN_MAX  = (longint'(1) << (TURN_W-1)) - 1;
    localparam longint TURN_MIN  = -(longint'(1) << (TURN_W-1));

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int ERR_SHOW      = 10;

    // Addresses beyond the coefficient bank; writes there must be ignored.
    localparam logic [2:0] SPARE_REG_LO = 3'd6;
    localparam logic [2:0] SPARE_REG_HI = 3'd7;

    // Coefficient sets, register 0 in the lowest 16 bits.
    localparam logic [6*COEF_BITS-1:0] DEFAULT_COEFS =
        {-16'sd15757, -16'sd316, 16'sd7800, -16'sd9069, 16'sd8189, -16'sd4162};
    localparam logic [6*COEF_BITS-1:0] IDENTITY_COEFS =
        {16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    localparam logic [6*COEF_BITS-1:0] ALL_MAX_COEFS = {6{16'h7fff}};
    localparam logic [6*COEF_BITS-1:0] ALL_MIN_COEFS = {6{16'h8000}};
    localparam logic [6*COEF_BITS-1:0] SPLIT_COEFS   = {{3{16'h7fff}}, {3{16'h8000}}};

    typedef struct packed {
        logic signed [PHASE_BITS-1:0] phase;
        logic signed [ANGLE_W:0]      angle;
        logic signed [TURN_W-1:0]     turns;
        logic                         sat;
    } unwrap_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // x_sample, y_sample, z_sample, zero padding
    logic [IN_W-1:0]          s_axis_tdata = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // unwrapped_phase, wrapped_angle, turn_count, zero padding
    logic [OUT_W-1:0]         m_axis_tdata;
    // turn_saturated
    logic                     m_axis_tuser;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_BITS-1:0]     paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Model state and coefficient shadow.
    logic signed [COEF_BITS-1:0] coef_shadow [0:NUM_COEFS-1];
    longint last_phase;
    longint turn_total;

    logic [IN_W-1:0]  fringe_triples [$];
    unwrap_result_t   pending_unwraps [$];
    int               items_issued = 0;
    int               results_checked = 0;
    int               error_count = 0;
    int               cycle_count = 0;
    logic             in_accepted = 1'b0;
    int               burst_left = 0;
    int               gap_left = 0;
    int               ready_span = 0;
    logic [15:0]      ready_mask = 16'hffff;
    logic [3:0]       ready_pos = '0;

    three_fringe_phase_unwrap dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= ERR_SHOW)
            $display("%s", msg);
    endfunction

    // atan(2^-i) with 2^32 units per turn.
    function automatic longint atan_entry(input int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            default: return 0;
        endcase
    endfunction

    // Vectoring CORDIC angle of (c, s), one turn = 2^ANGLE_W.
    function automatic longint cordic_angle(input longint c_in, input longint s_in);
        longint c;
        longint s;
        longint nc;
        longint acc;
        longint r;
        int i;
        c = c_in;
        s = s_in;
        acc = 0;
        if (c == 0 && s == 0)
            return 0;
        // Fold the left half plane over by half a turn.
        if (c < 0)
        begin
            acc = (s >= 0) ? HALF_ACC : -HALF_ACC;
            c = -c;
            s = -s;
        end
        for (i = 0; i < CORDIC_ITERS; i++)
        begin
            if (s > 0)
            begin
                nc = c + (s >>> i);
                s = s - (c >>> i);
                acc += atan_entry(i);
            end
            else
            begin
                nc = c - (s >>> i);
                s = s + (c >>> i);
                acc -= atan_entry(i);
            end
            c = nc;
        end
        // Round half up on a biased copy, then clamp to plus or minus half a turn.
        r = ((acc + (longint'(1) << 33) + (longint'(1) << (ACC_SHIFT-1))) >>> ACC_SHIFT)
            - (longint'(1) << (33-ACC_SHIFT));
        if (r > HALF_TURN)
            r = HALF_TURN;
        if (r < -HALF_TURN)
            r = -HALF_TURN;
        return r;
    endfunction

    // Demodulate one triple and unwrap it against the stored phase.
    function automatic unwrap_result_t predict_unwrap(input logic [IN_W-1:0] triple);
        logic signed [SAMPLE_W-1:0]   xv;
        logic signed [SAMPLE_W-1:0]   yv;
        logic signed [SAMPLE_W-1:0]   zv;
        logic signed [PHASE_BITS-1:0] wrapped;
        longint xs;
        longint ys;
        longint zs;
        longint cterm;
        longint sterm;
        longint ang;
        longint pnew;
        longint diff;
        unwrap_result_t res;
        xv = triple[SAMPLE_W-1:0];
        yv = triple[2*SAMPLE_W-1:SAMPLE_W];
        zv = triple[3*SAMPLE_W-1:2*SAMPLE_W];
        xs = xv;
        ys = yv;
        zs = zv;
        cterm = coef_shadow[REG_COS_X] * xs + coef_shadow[REG_COS_Y] * ys
              + coef_shadow[REG_COS_Z] * zs;
        sterm = coef_shadow[REG_SIN_X] * xs + coef_shadow[REG_SIN_Y] * ys
              + coef_shadow[REG_SIN_Z] * zs;
        ang = cordic_angle(cterm, sterm);
        pnew = ang + turn_total * ONE_TURN;
        diff = pnew - last_phase;
        if (diff < 0)
            diff = -diff;
        res.sat = 1'b0;
        if (diff > HALF_TURN)
        begin
            if (pnew < last_phase)
            begin
                if (turn_total < TURN_MAX)
                begin
                    turn_total++;
                    pnew += ONE_TURN;
                end
                else
                    res.sat = 1'b1;
            end
            else
            begin
                if (turn_total > TURN_MIN)
                begin
                    turn_total--;
                    pnew -= ONE_TURN;
                end
                else
                    res.sat = 1'b1;
            end
        end
        wrapped = pnew[PHASE_BITS-1:0];
        last_phase = wrapped;
        res.phase = wrapped;
        res.angle = ang[ANGLE_W:0];
        res.turns = turn_total[TURN_W-1:0];
        return res;
    endfunction

    // Input driver: bursts of transactions separated by random gaps.
    always @(negedge clk)
    begin : triple_driver
        logic slot_free;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else
        begin
            slot_free = !s_axis_tvalid || in_accepted;
            if (slot_free)
            begin
                if (gap_left > 0 || fringe_triples.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tdata <= fringe_triples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 12);
                    burst_left--;
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
            end
        end
    end

    // Result sink: ready follows a rotating mask that is redrawn after a random span.
    always @(negedge clk)
    begin : result_sink
        if (ready_span == 0)
        begin
            ready_span = $urandom_range(30, 400);
            case ($urandom_range(0, 2))
                0:       ready_mask = 16'hffff;
                1:       ready_mask = 16'($urandom) | 16'h0001;
                default: ready_mask = (16'($urandom) & 16'($urandom)) | 16'h0001;
            endcase
        end
        ready_span--;
        ready_pos = ready_pos + 4'd1;
        m_axis_tready <= ready_mask[ready_pos];
    end

    // Monitor: check each result transaction, then predict each accepted input.
    always @(posedge clk)
    begin : result_monitor
        unwrap_result_t got;
        unwrap_result_t want;
        if (!rst_n)
            in_accepted = 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.phase = m_axis_tdata[PHASE_BITS-1:0];
                got.angle = m_axis_tdata[PHASE_BITS+ANGLE_W:PHASE_BITS];
                got.turns = m_axis_tdata[PHASE_BITS+ANGLE_W+TURN_W:PHASE_BITS+ANGLE_W+1];
                got.sat = m_axis_tuser;
                if (pending_unwraps.size() == 0)
                    note_error($sformatf("%0t: result with nothing expected", $realtime));
                else
                begin
                    want = pending_unwraps.pop_front();
                    if (got.phase !== want.phase || got.angle !== want.angle ||
                        got.turns !== want.turns || got.sat !== want.sat)
                        note_error($sformatf({"%0t: result %0d expected phase %0d angle %0d",
                            " turns %0d sat %0b, got phase %0d angle %0d turns %0d sat %0b"},
                            $realtime, results_checked, want.phase, want.angle, want.turns,
                            want.sat, got.phase, got.angle, got.turns, got.sat));
                    results_checked++;
                end
            end
            in_accepted = s_axis_tvalid && s_axis_tready;
            if (in_accepted)
                pending_unwraps.push_back(predict_unwrap(s_axis_tdata));
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL three_fringe_phase_unwrap");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [COEF_BITS-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {{(APB_DATA_BITS-COEF_BITS){val[COEF_BITS-1]}}, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx < NUM_COEFS)
            coef_shadow[idx] = val;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Read every coefficient back and compare the low half word.
    task automatic check_coefs();
        int i;
        for (i = 0; i < NUM_COEFS; i++)
        begin
            @(negedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {i[2:0], 2'b00};
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            if (prdata[COEF_BITS-1:0] !== coef_shadow[i])
                note_error($sformatf("%0t: register %0d read %0d, expected %0d", $realtime, i,
                    $signed(prdata[COEF_BITS-1:0]), coef_shadow[i]));
            @(negedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic load_coefs(input logic [6*COEF_BITS-1:0] set);
        int i;
        for (i = 0; i < NUM_COEFS; i++)
            apb_write(i[2:0], set[COEF_BITS*i +: COEF_BITS]);
        check_coefs();
    endtask

    task automatic queue_triple(input logic [15:0] xv, input logic [15:0] yv,
                                input logic [15:0] zv);
        fringe_triples.push_back({zv, yv, xv});
        items_issued++;
    endtask

    // Sample values weighted toward the extremes.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] real_to_sample(input real v);
        int n;
        n = $rtoi(v + ((v >= 0.0) ? 0.5 : -0.5));
        if (n > 32767)
            n = 32767;
        if (n < -32768)
            n = -32768;
        return n[15:0];
    endfunction

    // A rotating fringe vector for the identity mapping (C = x, S = y), with
    // occasional jumps of any size.
    task automatic queue_spin(input int len);
        real theta;
        real step;
        real amp;
        int n;
        theta = $urandom_range(0, 65535) / 65536.0;
        step = ($urandom_range(0, 58000) - 29000.0) / 65536.0;
        amp = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1000, 32767);
        for (n = 0; n < len; n++)
        begin
            queue_triple(real_to_sample(amp * $cos(2.0 * 3.14159265358979 * theta)),
                         real_to_sample(amp * $sin(2.0 * 3.14159265358979 * theta)),
                         pick_sample());
            if ($urandom_range(0, 15) == 0)
                theta += $urandom_range(0, 65535) / 65536.0;
            else
                theta += step + ($urandom_range(0, 200) - 100.0) / 65536.0;
        end
    endtask

    task automatic queue_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            queue_triple(pick_sample(), pick_sample(), pick_sample());
    endtask

    // Wait until every accepted transaction has produced its result.
    task automatic settle();
        while (results_checked != items_issued)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin : stimulus
        int i;
        int spun;
        for (i = 0; i < NUM_COEFS; i++)
            coef_shadow[i] = DEFAULT_COEFS[COEF_BITS*i +: COEF_BITS];
        last_phase = 0;
        turn_total = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Reset coefficients: zero vector and sample extremes.
        queue_triple(16'h0000, 16'h0000, 16'h0000);
        queue_triple(16'h7fff, 16'h7fff, 16'h7fff);
        queue_triple(16'h8000, 16'h8000, 16'h8000);
        queue_triple(16'h7fff, 16'h8000, 16'h0000);
        queue_triple(16'h8000, 16'h7fff, 16'h8000);
        queue_triple(16'h0001, 16'hffff, 16'h0000);
        queue_random(90);
        settle();

        // Identity mapping: axis directions, the half-turn folds and a crossing of
        // the negative axis that must step the turn count.
        load_coefs(IDENTITY_COEFS);
        apb_write(SPARE_REG_LO, 16'h1234);
        apb_write(SPARE_REG_HI, 16'hfedc);
        check_coefs();
        queue_triple(16'h7fff, 16'h0000, 16'h5555);
        queue_triple(16'h8000, 16'h0000, 16'haaaa);
        queue_triple(16'h8000, 16'hffff, 16'h0000);
        queue_triple(16'h0000, 16'h7fff, 16'h0000);
        queue_triple(16'h0000, 16'h8000, 16'h0000);
        queue_triple(16'hffff, 16'hffff, 16'h0000);
        queue_triple(16'h0001, 16'h0000, 16'h0000);
        queue_triple(16'h8000, 16'h0001, 16'h0000);
        queue_triple(16'h8000, 16'hffff, 16'h0000);
        queue_triple(16'h8000, 16'h0001, 16'h0000);
        queue_triple(16'h0000, 16'h0000, 16'h0000);
        spun = 0;
        while (spun < 550)
        begin
            i = $urandom_range(8, 40);
            queue_spin(i);
            spun += i;
        end
        settle();

        // Coefficient extremes.
        load_coefs(ALL_MAX_COEFS);
        queue_random(120);
        settle();
        load_coefs(ALL_MIN_COEFS);
        queue_random(120);
        settle();
        load_coefs(SPLIT_COEFS);
        queue_random(120);
        settle();

        // Random coefficient sets.
        for (i = 0; i < 3; i++)
        begin
            load_coefs({$urandom, $urandom, $urandom});
            queue_random(130);
            settle();
        end

        // Back to the reset values.
        load_coefs(DEFAULT_COEFS);
        queue_random(120);
        settle();

        if (pending_unwraps.size() != 0)
            note_error($sformatf("%0d results never arrived", pending_unwraps.size()));
        if (error_count == 0)
            $display("PASS three_fringe_phase_unwrap");
        else
            $display("FAIL three_fringe_phase_unwrap");
        $finish;
    end

endmodule
